### hdl/cdq_pkg.sv
package cdq_pkg;

  // Width of the index, count and capacity fields.
  localparam int unsigned CntW = 4;

  // Largest capacity that the register can express.
  localparam int unsigned CapMax = 15;

  // Capacity after reset.
  localparam logic [CntW-1:0] CapReset = 4'd8;

  // Position code reported while the deque is empty.
  localparam logic [CntW-1:0] PosNone = 4'hF;

  // Requested operation of an input beat.
  typedef enum logic [1:0] {
    OpPushFront = 2'd0,
    OpPushRear  = 2'd1,
    OpPopFront  = 2'd2,
    OpPopRear   = 2'd3
  } op_e;

  // Outcome reported with every result beat.
  typedef enum logic [1:0] {
    StatDone  = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  // Command broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic            push_front;
    logic            pop_front;
    logic            push_rear;
    logic [CntW-1:0] count;
  } cmd_t;

endpackage

### hdl/cdq_cell.sv
// One cell of the deque chain. Cell number IDX holds the entry that sits IDX
// places behind the front. A push at the front moves every entry one cell back,
// a pop at the front moves every entry one cell forward, and a push at the rear
// lands in the first free cell.
module cdq_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cdq_pkg::cmd_t         cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  last_o
);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;
  logic                  here;

  // This cell is the first free one for a push at the rear.
  assign here = (cmd_i.count == cdq_pkg::CntW'(IDX));

  // Select the word this cell takes in the current cycle.
  always_comb begin
    data_d = data_q;
    if (cmd_i.push_front) begin
      data_d = left_i;
    end else if (cmd_i.pop_front) begin
      data_d = right_i;
    end else if (cmd_i.push_rear && here) begin
      data_d = value_i;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // The cell holds the rear entry when the count ends right after it.
  assign last_o = (cmd_i.count == cdq_pkg::CntW'(IDX + 1));

endmodule

### hdl/circular_deque.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  operation_i, value_i
// out       output     out_valid_o / out_ready_i
//                                               status_o, front/rear position and value,
//                                               count_o, is_empty_o, is_full_o
// capacity  input      capacity_we_i            capacity_i
//
// For an input beat, the cell chain, front index and count update at the edge that
// accepts the beat, and the result register loads once it is empty or being read.
// One beat is in flight at a time.
// After reset the deque is empty and the capacity is 8; no clearing pass runs.
// A stall on the output holds the finished result, and the input stays closed
// until that result has moved into the output register.
module circular_deque #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic signed [DATA_WIDTH-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic signed [3:0]             front_position_o,
  output logic signed [3:0]             rear_position_o,
  output logic signed [DATA_WIDTH-1:0]  front_value_o,
  output logic signed [DATA_WIDTH-1:0]  rear_value_o,
  output logic [3:0]                    count_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  input  logic                          capacity_we_i,
  input  logic [3:0]                    capacity_i
);

  localparam int unsigned CntW  = cdq_pkg::CntW;
  // Capacity never exceeds the register range, so cells past it are never used.
  localparam int unsigned Cells = (DEPTH < cdq_pkg::CapMax) ? DEPTH : cdq_pkg::CapMax;

  logic [CntW-1:0]       cap_q;
  logic [CntW-1:0]       eff_cap;
  logic [CntW-1:0]       front_q, front_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  pending_q;
  cdq_pkg::status_e      stat_q, stat_d;
  logic                  in_acc;
  logic                  is_full, is_empty;
  logic                  capture;
  cdq_pkg::op_e          op;
  cdq_pkg::cmd_t         cmd;
  logic [DATA_WIDTH-1:0] cell_data [Cells];
  logic [Cells-1:0]      cell_last;
  logic [DATA_WIDTH-1:0] rear_word;
  logic [CntW:0]         rear_sum;
  logic [CntW-1:0]       rear_pos;

  logic                  out_valid_q;
  cdq_pkg::status_e      out_stat_q;
  logic [CntW-1:0]       out_front_pos_q, out_rear_pos_q, out_count_q;
  logic [DATA_WIDTH-1:0] out_front_val_q, out_rear_val_q;
  logic                  out_empty_q, out_full_q;

  assign op         = cdq_pkg::op_e'(operation_i);
  assign in_ready_o = !pending_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign capture    = pending_q && (!out_valid_q || out_ready_i);

  // A capacity of zero acts as one; anything above the cell count is clamped.
  always_comb begin
    eff_cap = (cap_q == '0) ? CntW'(1) : cap_q;
    if (eff_cap > CntW'(Cells)) begin
      eff_cap = CntW'(Cells);
    end
  end

  assign is_full  = (count_q == eff_cap);
  assign is_empty = (count_q == '0);

  // Next front index, count and status for an accepted beat.
  always_comb begin
    front_d        = front_q;
    count_d        = count_q;
    stat_d         = stat_q;
    cmd.push_front = 1'b0;
    cmd.pop_front  = 1'b0;
    cmd.push_rear  = 1'b0;
    cmd.count      = count_q;
    if (in_acc) begin
      stat_d = cdq_pkg::StatDone;
      unique case (op)
        cdq_pkg::OpPushFront, cdq_pkg::OpPushRear: begin
          if (is_full) begin
            stat_d = cdq_pkg::StatFull;
          end else begin
            count_d = count_q + CntW'(1);
            if (op == cdq_pkg::OpPushFront) begin
              cmd.push_front = 1'b1;
              front_d = (front_q == '0) ? eff_cap - CntW'(1) : front_q - CntW'(1);
            end else begin
              cmd.push_rear = 1'b1;
            end
          end
        end
        cdq_pkg::OpPopFront, cdq_pkg::OpPopRear: begin
          if (is_empty) begin
            stat_d = cdq_pkg::StatEmpty;
          end else begin
            count_d = count_q - CntW'(1);
            if (op == cdq_pkg::OpPopFront) begin
              cmd.pop_front = 1'b1;
              front_d = (front_q + CntW'(1) == eff_cap) ? '0 : front_q + CntW'(1);
            end
          end
        end
        default: begin
          stat_d = cdq_pkg::StatDone;
        end
      endcase
    end
  end

  // Control state; a capacity write also empties the deque.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= cdq_pkg::CapReset;
      front_q   <= '0;
      count_q   <= '0;
      pending_q <= 1'b0;
      stat_q    <= cdq_pkg::StatDone;
    end else begin
      stat_q <= stat_d;
      if (capacity_we_i) begin
        cap_q   <= capacity_i;
        front_q <= '0;
        count_q <= '0;
      end else begin
        front_q <= front_d;
        count_q <= count_d;
      end
      if (in_acc) begin
        pending_q <= 1'b1;
      end else if (capture) begin
        pending_q <= 1'b0;
      end
    end
  end

  // The chain of cells, front entry in cell zero.
  for (genvar k = 0; k < Cells; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (k == 0) begin : g_head
      assign left_w = value_i;
    end else begin : g_body
      assign left_w = cell_data[k-1];
    end
    if (k == Cells - 1) begin : g_tail
      assign right_w = cell_data[k];
    end else begin : g_inner
      assign right_w = cell_data[k+1];
    end
    cdq_cell #(
      .IDX       (k),
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .value_i(value_i),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cell_data[k]),
      .last_o (cell_last[k])
    );
  end

  // Gather the rear word from the one cell that flags itself as last.
  always_comb begin
    rear_word = '0;
    for (int k = 0; k < Cells; k++) begin
      rear_word = rear_word | (cell_data[k] & {DATA_WIDTH{cell_last[k]}});
    end
  end

  // Rear position wraps at the capacity.
  always_comb begin
    rear_sum = {1'b0, front_q} + {1'b0, count_q} - (CntW+1)'(1);
    if (rear_sum >= {1'b0, eff_cap}) begin
      rear_sum = rear_sum - {1'b0, eff_cap};
    end
    rear_pos = rear_sum[CntW-1:0];
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (capture) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_stat_q  <= stat_q;
      out_count_q <= count_q;
      out_empty_q <= is_empty;
      out_full_q  <= is_full;
      if (is_empty) begin
        out_front_pos_q <= cdq_pkg::PosNone;
        out_rear_pos_q  <= cdq_pkg::PosNone;
        out_front_val_q <= '1;
        out_rear_val_q  <= '1;
      end else begin
        out_front_pos_q <= front_q;
        out_rear_pos_q  <= rear_pos;
        out_front_val_q <= cell_data[0];
        out_rear_val_q  <= rear_word;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_stat_q;
  assign front_position_o = out_front_pos_q;
  assign rear_position_o  = out_rear_pos_q;
  assign front_value_o    = out_front_val_q;
  assign rear_value_o     = out_rear_val_q;
  assign count_o          = out_count_q;
  assign is_empty_o       = out_empty_q;
  assign is_full_o        = out_full_q;

`ifndef SYNTHESIS
  // The count never passes the effective capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= eff_cap)
    else $error("deque count exceeds capacity");

  // The front index stays inside the capacity.
  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q < eff_cap)
    else $error("front index outside capacity");

  // A successful push grows the count by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !capacity_we_i && (op == cdq_pkg::OpPushFront || op == cdq_pkg::OpPushRear)
     && !is_full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("push did not grow the count");

  // The empty flag of a result agrees with its count.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_empty_q == (out_count_q == '0)))
    else $error("empty flag disagrees with count");

  // No new beat is taken while a result is still being formed.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("second beat taken while one is pending");
`endif

endmodule

### verif/tb_circular_deque.sv
`timescale 1ns / 100ps

module tb_circular_deque;

  // One requested operation as it is sent on the input channel.
  typedef struct packed {
    cdq_pkg::op_e       op;
    logic signed [31:0] word;
  } deque_cmd_t;

  // The deque as reported by one result beat.
  typedef struct packed {
    cdq_pkg::status_e   status;
    logic signed [3:0]  front_pos;
    logic signed [3:0]  rear_pos;
    logic signed [31:0] front_val;
    logic signed [31:0] rear_val;
    logic [3:0]         count;
    logic               is_empty;
    logic               is_full;
  } deque_view_t;

  localparam int unsigned StoreDepth = 8;
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned LongStall  = 300;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 143;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = 2'd0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [3:0]  front_position_o;
  logic signed [3:0]  rear_position_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] rear_value_o;
  logic [3:0]         count_o;
  logic               is_empty_o;
  logic               is_full_o;
  logic               capacity_we_i = 1'b0;
  logic [3:0]         capacity_i = cdq_pkg::CapReset;

  // Shadow copy of the deque used to work out each expected result.
  logic signed [31:0] dq_store [StoreDepth];
  int unsigned        dq_front = 0;
  int unsigned        dq_held = 0;
  int unsigned        dq_cap = 8;

  deque_cmd_t  pending_cmds [$];
  deque_view_t expected_views [$];
  deque_cmd_t  next_cmd;
  deque_cmd_t  seen_cmd;
  deque_view_t got_view;
  deque_view_t want_view;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] clk_count = '0;
  logic        in_beat_taken = 1'b0;
  logic        out_beat_taken;
  logic        calm;
  logic        stall_requested = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  logic [3:0]  phase_caps [NumPhases];

  circular_deque #(
    .DEPTH      (8),
    .DATA_WIDTH (32)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .front_position_o (front_position_o),
    .rear_position_o  (rear_position_o),
    .front_value_o    (front_value_o),
    .rear_value_o     (rear_value_o),
    .count_o          (count_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o),
    .capacity_we_i    (capacity_we_i),
    .capacity_i       (capacity_i)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Both sides stop idling for a stretch at the start of each window of the clock counter.
  assign calm = (clk_count % 512) < 96;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random data word with the extremes mixed in.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Apply one operation to the shadow deque and return the view it leaves.
  function automatic deque_view_t apply_cmd(deque_cmd_t c);
    deque_view_t v;
    int unsigned slot;
    int unsigned rear;
    v.status = cdq_pkg::StatDone;
    if (c.op == cdq_pkg::OpPushFront || c.op == cdq_pkg::OpPushRear) begin
      if (dq_held == dq_cap) begin
        v.status = cdq_pkg::StatFull;
      end else begin
        if (c.op == cdq_pkg::OpPushFront) begin
          dq_front = (dq_front == 0) ? dq_cap - 1 : dq_front - 1;
          slot = dq_front;
        end else begin
          slot = dq_front + dq_held;
          if (slot >= dq_cap) slot -= dq_cap;
        end
        dq_store[slot] = c.word;
        dq_held++;
      end
    end else begin
      if (dq_held == 0) begin
        v.status = cdq_pkg::StatEmpty;
      end else begin
        if (c.op == cdq_pkg::OpPopFront) begin
          dq_front++;
          if (dq_front >= dq_cap) dq_front = 0;
        end
        dq_held--;
      end
    end
    // An empty deque reports -1 for both ends.
    if (dq_held == 0) begin
      v.front_pos = cdq_pkg::PosNone;
      v.rear_pos  = cdq_pkg::PosNone;
      v.front_val = -32'sd1;
      v.rear_val  = -32'sd1;
    end else begin
      rear = dq_front + dq_held - 1;
      if (rear >= dq_cap) rear -= dq_cap;
      v.front_pos = 4'(dq_front);
      v.rear_pos  = 4'(rear);
      v.front_val = dq_store[dq_front];
      v.rear_val  = dq_store[rear];
    end
    v.count    = 4'(dq_held);
    v.is_empty = (dq_held == 0);
    v.is_full  = (dq_held == dq_cap);
    return v;
  endfunction

  // Write the capacity register; this also empties the deque.
  task automatic write_capacity(input logic [3:0] cap);
    @(negedge clk_i);
    capacity_we_i <= 1'b1;
    capacity_i    <= cap;
    @(negedge clk_i);
    capacity_we_i <= 1'b0;
    // A capacity of zero acts as one, and anything above the store acts as its depth.
    dq_cap   = (cap == 0) ? 1 : (cap > StoreDepth) ? StoreDepth : cap;
    dq_front = 0;
    dq_held  = 0;
    @(posedge clk_i);
  endtask

  task automatic queue_cmd(input cdq_pkg::op_e op, input logic signed [31:0] word);
    deque_cmd_t c;
    c.op   = op;
    c.word = word;
    pending_cmds.push_back(c);
  endtask

  // Random operations in runs that lean toward pushes or toward pops, so the
  // deque keeps reaching both full and empty.
  task automatic queue_random(input int unsigned n);
    int unsigned left;
    int unsigned seg;
    int unsigned push_pct;
    left = n;
    while (left > 0) begin
      seg      = $urandom_range(5, 30);
      push_pct = $urandom_range(0, 1) ? 75 : 25;
      if (seg > left) seg = left;
      repeat (seg) begin
        if ($urandom_range(0, 99) < push_pct)
          queue_cmd($urandom_range(0, 1) ? cdq_pkg::OpPushRear : cdq_pkg::OpPushFront,
                    pick_word());
        else
          queue_cmd($urandom_range(0, 1) ? cdq_pkg::OpPopRear : cdq_pkg::OpPopFront,
                    pick_word());
      end
      left -= seg;
    end
  endtask

  // Wait until every queued beat has been sent and every result has come back.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid_i || expected_views.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Input driver: holds a beat until it is taken, then inserts a random gap.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_beat_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= next_cmd.op;
        value_i     <= next_cmd.word;
        in_gap = calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (stall_requested) begin
      stall_requested = 1'b0;
      out_hold = LongStall;
    end
    if (out_hold > 0) begin
      out_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) out_hold = pick_gap();
    end
  end

  // Monitor: checks result beats, predicts accepted input beats, and guards
  // against a hang.
  always @(posedge clk_i) begin
    clk_count <= clk_count + 1;
    in_beat_taken  = rst_ni && in_valid_i && in_ready_o;
    out_beat_taken = rst_ni && out_valid_o && out_ready_i;

    if (out_beat_taken) begin
      got_view.status    = cdq_pkg::status_e'(status_o);
      got_view.front_pos = front_position_o;
      got_view.rear_pos  = rear_position_o;
      got_view.front_val = front_value_o;
      got_view.rear_val  = rear_value_o;
      got_view.count     = count_o;
      got_view.is_empty  = is_empty_o;
      got_view.is_full   = is_full_o;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: st=%0d fp=%0d rp=%0d fv=%0d rv=%0d cnt=%0d",
                   got_view.status, got_view.front_pos, got_view.rear_pos,
                   got_view.front_val, got_view.rear_val, got_view.count);
      end else begin
        want_view = expected_views.pop_front();
        if (got_view !== want_view) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected: st=%0d fp=%0d rp=%0d fv=%0d rv=%0d cnt=%0d e=%0b f=%0b",
                     want_view.status, want_view.front_pos, want_view.rear_pos,
                     want_view.front_val, want_view.rear_val, want_view.count,
                     want_view.is_empty, want_view.is_full);
            $display("actual:   st=%0d fp=%0d rp=%0d fv=%0d rv=%0d cnt=%0d e=%0b f=%0b",
                     got_view.status, got_view.front_pos, got_view.rear_pos,
                     got_view.front_val, got_view.rear_val, got_view.count,
                     got_view.is_empty, got_view.is_full);
          end
        end
      end
    end

    if (in_beat_taken) begin
      seen_cmd.op   = cdq_pkg::op_e'(operation_i);
      seen_cmd.word = value_i;
      expected_views.push_back(apply_cmd(seen_cmd));
    end

    // Watchdog on cycles without any accepted beat.
    if (in_beat_taken || out_beat_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: pops on an empty deque, a fill that wraps the front index,
    // pushes on a full deque, then a drain from both ends.
    queue_cmd(cdq_pkg::OpPopFront, 32'sd5);
    queue_cmd(cdq_pkg::OpPopRear, 32'sd6);
    queue_cmd(cdq_pkg::OpPushFront, 32'sh8000_0000);
    queue_cmd(cdq_pkg::OpPushRear, 32'sh7FFF_FFFF);
    queue_cmd(cdq_pkg::OpPushFront, 32'sd0);
    queue_cmd(cdq_pkg::OpPushRear, -32'sd1);
    queue_cmd(cdq_pkg::OpPushFront, 32'sh5A5A_5A5A);
    queue_cmd(cdq_pkg::OpPushRear, 32'shA5A5_A5A5);
    queue_cmd(cdq_pkg::OpPushFront, 32'sd1);
    queue_cmd(cdq_pkg::OpPushRear, 32'shFFFF_0000);
    queue_cmd(cdq_pkg::OpPushRear, 32'sd3);
    queue_cmd(cdq_pkg::OpPushFront, 32'sd4);
    repeat (4) begin
      queue_cmd(cdq_pkg::OpPopFront, 32'sd0);
      queue_cmd(cdq_pkg::OpPopRear, 32'sd0);
    end
    queue_cmd(cdq_pkg::OpPopFront, 32'sd0);
    wait_idle();

    // Random phases, each under its own capacity, including zero and the maximum.
    phase_caps = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd8, 4'd5, 4'd3, 4'd0, 4'd7, 4'd0};
    phase_caps[7] = 4'($urandom_range(0, 15));
    phase_caps[9] = 4'($urandom_range(0, 15));
    for (int i = 0; i < NumPhases; i++) begin
      write_capacity(phase_caps[i]);
      // Hold the output off long enough for the input side to back up.
      if (i == 2) stall_requested = 1'b1;
      queue_random(PhaseItems);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hdl/cdq_pkg.sv
hdl/cdq_cell.sv
hdl/circular_deque.sv
verif/tb_circular_deque.sv
